[rtl/color_contrast_ratio_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the color contrast ratio block
// Implication checks on the block clock, held off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef COLOR_CONTRAST_RATIO_ASSERT_SVH
`define COLOR_CONTRAST_RATIO_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds at the same edge.
`define CCR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define CCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ccr_pkg.sv]
// ----------------------------------------------------------------------------
// ccr_pkg
// Widths, fixed-point constants, beat types and elaboration-time helpers for
// the color contrast ratio pipeline.
// ----------------------------------------------------------------------------
package ccr_pkg;

  // Field widths
  localparam int unsigned CHANNEL_BITS        = 8;
  localparam int unsigned LUMA_FRACTION_BITS  = 16;
  localparam int unsigned RATIO_FRACTION_BITS = 8;
  localparam int unsigned RATIO_INT_BITS      = 5;
  localparam int unsigned RATIO_W             = RATIO_FRACTION_BITS + RATIO_INT_BITS;
  localparam int unsigned LUMA_PAIR_W         = 2 * LUMA_FRACTION_BITS;

  // Working format: unsigned Q0.30, value range [0, 1.0] needs 31 bits
  localparam int unsigned WORK_BITS = 30;
  localparam int unsigned LIN_W     = WORK_BITS + 1;

  // Weighted sum 2126 R + 7152 G + 722 B, at most 10000 * 2^30
  localparam int unsigned SUM_W = 44;
  localparam logic [SUM_W-1:0] W_RED   = SUM_W'(2126);
  localparam logic [SUM_W-1:0] W_GREEN = SUM_W'(7152);
  localparam logic [SUM_W-1:0] W_BLUE  = SUM_W'(722);

  // Divide by 10000 as a shift by 4 then a divide by 625 through a reciprocal
  localparam int unsigned DIV_SHIFT = 4;
  localparam int unsigned A_W       = SUM_W - DIV_SHIFT;
  localparam int unsigned A_HALF    = A_W / 2;
  localparam int unsigned K_W       = 31;
  localparam logic [K_W-1:0] RECIP_K = K_W'(1759218604);  // floor(2^40 / 625)
  localparam int unsigned P_W       = A_HALF + K_W;
  localparam int unsigned EST_W     = P_W + A_HALF;
  localparam logic [A_W-1:0] DIV_ODD = A_W'(625);

  // Ratio numerator and denominator: 20 Y + 1.0, at most 21 * 2^30
  localparam int unsigned NUM_W = 35;
  localparam logic [NUM_W-1:0] RATIO_SCALE = NUM_W'(20);
  localparam logic [NUM_W-1:0] WORK_ONE    = NUM_W'(1) << WORK_BITS;

  // Pipeline shape
  localparam int unsigned LUMA_STAGES = 6;
  localparam int unsigned MID_STAGES  = 2;
  localparam int unsigned DIV_STAGES  = RATIO_W;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] first_red;
    logic [CHANNEL_BITS-1:0] first_green;
    logic [CHANNEL_BITS-1:0] first_blue;
    logic [CHANNEL_BITS-1:0] second_red;
    logic [CHANNEL_BITS-1:0] second_green;
    logic [CHANNEL_BITS-1:0] second_blue;
  } ccr_in_t;

  typedef struct packed {
    logic [LUMA_FRACTION_BITS-1:0] first_luminance;
    logic [LUMA_FRACTION_BITS-1:0] second_luminance;
    logic [RATIO_W-1:0]            contrast_value;
  } ccr_out_t;

  // Elaboration-time helpers for the linearization table

  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> WORK_BITS;
  endfunction

  function automatic longint unsigned fifth_pow(longint unsigned x);
    longint unsigned p;
    p = fx_mul(x, x);
    p = fx_mul(p, x);
    p = fx_mul(p, x);
    return fx_mul(p, x);
  endfunction

  // Find the largest r with r^5 <= sq (that is t^0.4), return sq * r
  function automatic longint unsigned root_mul(longint unsigned sq);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd1 << WORK_BITS;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      if (fifth_pow(mid) <= sq) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return fx_mul(sq, lo);
  endfunction

endpackage

[rtl/ccr_luma.sv]
// ----------------------------------------------------------------------------
// ccr_luma
// Six-stage relative luminance of one color: table linearization, weighted
// sum, and an exact divide by 10000 through a reciprocal with one correction.
// ----------------------------------------------------------------------------
module ccr_luma (
  input  logic                              clk,
  input  logic [ccr_pkg::LUMA_STAGES-1:0]   en,
  input  logic [ccr_pkg::CHANNEL_BITS-1:0]  red,
  input  logic [ccr_pkg::CHANNEL_BITS-1:0]  green,
  input  logic [ccr_pkg::CHANNEL_BITS-1:0]  blue,
  output logic [ccr_pkg::LIN_W-1:0]         luma
);
  import ccr_pkg::*;

  localparam int unsigned LUT_DEPTH = 1 << CHANNEL_BITS;
  localparam longint unsigned CODE_MAX = (64'd1 << CHANNEL_BITS) - 64'd1;
  localparam longint unsigned LOW_DIV  = 1292 * CODE_MAX;
  localparam longint unsigned HIGH_DIV = 1055 * CODE_MAX;

  logic [LIN_W-1:0] lut [LUT_DEPTH];

  // Linearization table, built at elaboration
  for (genvar g = 0; g < LUT_DEPTH; g++) begin : g_lut
    localparam longint unsigned C      = g;
    localparam bit              IS_LOW = (C * 100000) <= (3928 * CODE_MAX);
    localparam longint unsigned LOW_V  = ((C * 100) << WORK_BITS) / LOW_DIV;
    localparam longint unsigned T      = ((1000 * C + 55 * CODE_MAX) << WORK_BITS) / HIGH_DIV;
    localparam longint unsigned SQ     = (T * T) >> WORK_BITS;
    localparam longint unsigned V      = IS_LOW ? LOW_V : root_mul(SQ);
    assign lut[g] = LIN_W'(V);
  end

  logic [LIN_W-1:0] red_lin_r, green_lin_r, blue_lin_r;
  logic [A_W-1:0]   a2_r, a3_r, a4_r, a5_r;
  logic [P_W-1:0]   p_hi_r, p_lo_r;
  logic [LIN_W-1:0] qe_r, q5_r, y_r;
  logic [A_W-1:0]   m_r;

  logic [SUM_W-1:0] sum;
  logic [EST_W-1:0] est;
  logic [A_W-1:0]   rem;

  assign sum = SUM_W'(red_lin_r) * W_RED + SUM_W'(green_lin_r) * W_GREEN +
               SUM_W'(blue_lin_r) * W_BLUE;
  assign est = {p_hi_r, {A_HALF{1'b0}}} + EST_W'(p_lo_r);
  assign rem = a5_r - m_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      red_lin_r   <= lut[red];
      green_lin_r <= lut[green];
      blue_lin_r  <= lut[blue];
    end
    if (en[1]) begin
      a2_r <= sum[SUM_W-1:DIV_SHIFT];
    end
    if (en[2]) begin
      p_hi_r <= P_W'(a2_r[A_W-1:A_HALF]) * P_W'(RECIP_K);
      p_lo_r <= P_W'(a2_r[A_HALF-1:0]) * P_W'(RECIP_K);
      a3_r   <= a2_r;
    end
    if (en[3]) begin
      qe_r <= est[EST_W-1:A_W];
      a4_r <= a3_r;
    end
    if (en[4]) begin
      m_r  <= A_W'(qe_r) * DIV_ODD;
      q5_r <= qe_r;
      a5_r <= a4_r;
    end
    if (en[5]) begin
      // estimate is low by at most one
      y_r <= (rem >= DIV_ODD) ? q5_r + LIN_W'(1) : q5_r;
    end
  end

  assign luma = y_r;

endmodule

[rtl/ccr_div.sv]
// ----------------------------------------------------------------------------
// ccr_div
// Pipelined restoring divider for the contrast ratio, one quotient bit per
// stage, with a side tag that travels alongside each quotient.
// ----------------------------------------------------------------------------
module ccr_div (
  input  logic                             clk,
  input  logic [ccr_pkg::DIV_STAGES-1:0]   en,
  input  logic [ccr_pkg::NUM_W-1:0]        num,
  input  logic [ccr_pkg::NUM_W-1:0]        den,
  input  logic [ccr_pkg::LUMA_PAIR_W-1:0]  tag_in,
  output logic [ccr_pkg::RATIO_W-1:0]      quo,
  output logic [ccr_pkg::LUMA_PAIR_W-1:0]  tag_out
);
  import ccr_pkg::*;

  logic [NUM_W-1:0]       rem_r  [DIV_STAGES];
  logic [NUM_W-1:0]       den_r  [DIV_STAGES];
  logic [RATIO_W-1:0]     bits_r [DIV_STAGES];
  logic [RATIO_W-1:0]     q_r    [DIV_STAGES];
  logic [LUMA_PAIR_W-1:0] tag_r  [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
    logic [NUM_W-1:0]       rem_src;
    logic [NUM_W-1:0]       den_src;
    logic [RATIO_W-1:0]     bits_src;
    logic [RATIO_W-1:0]     q_src;
    logic [LUMA_PAIR_W-1:0] tag_src;
    logic [NUM_W:0]         trial;
    logic                   fits;

    if (j == 0) begin : g_first
      // quotient fits RATIO_W bits, so the top of the dividend is below den
      assign rem_src  = num >> RATIO_INT_BITS;
      assign den_src  = den;
      assign bits_src = {num[RATIO_INT_BITS-1:0], {RATIO_FRACTION_BITS{1'b0}}};
      assign q_src    = '0;
      assign tag_src  = tag_in;
    end else begin : g_next
      assign rem_src  = rem_r[j-1];
      assign den_src  = den_r[j-1];
      assign bits_src = bits_r[j-1];
      assign q_src    = q_r[j-1];
      assign tag_src  = tag_r[j-1];
    end

    assign trial = {rem_src, bits_src[RATIO_W-1]};
    assign fits  = trial >= {1'b0, den_src};

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j]  <= fits ? NUM_W'(trial - {1'b0, den_src}) : trial[NUM_W-1:0];
        den_r[j]  <= den_src;
        bits_r[j] <= bits_src << 1;
        q_r[j]    <= {q_src[RATIO_W-2:0], fits};
        tag_r[j]  <= tag_src;
      end
    end
  end

  assign quo     = q_r[DIV_STAGES-1];
  assign tag_out = tag_r[DIV_STAGES-1];

endmodule

[rtl/color_contrast_ratio.sv]
// ----------------------------------------------------------------------------
// color_contrast_ratio
// Relative luminance of two sRGB colors and their contrast ratio.
// ----------------------------------------------------------------------------
// One color pair enters per clock while in_stall is low and passes through six
// stages per color for the luminance (table linearization, weighted sum, and
// a reciprocal-based divide by 10000), one stage to order the luminances, one
// to form 20 Y + 1.0, and thirteen stages of restoring division that each
// produce one bit of the Q5.8 ratio. Every stage carries a valid bit; a stage
// loads whenever it or any stage after it is empty or the output beat is
// taken, so bubbles collapse and in_stall only rises when every stage holds a
// beat and out_stall is high. Luminance outputs are Q0.16, saturated at
// 65535; the ratio comes from the unsaturated values and runs from 1.0 to 21.0.
// ----------------------------------------------------------------------------
`include "color_contrast_ratio_assert.svh"

module color_contrast_ratio (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ccr_pkg::ccr_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ccr_pkg::ccr_out_t out_data
);
  import ccr_pkg::*;

  localparam int unsigned NST = LUMA_STAGES + MID_STAGES + DIV_STAGES;
  localparam int unsigned CMP = LUMA_STAGES;
  localparam int unsigned PRP = LUMA_STAGES + 1;
  localparam int unsigned DV0 = LUMA_STAGES + MID_STAGES;
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRACTION_BITS;
  localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(21) << RATIO_FRACTION_BITS;

  // Shift down to the output fraction and clamp 1.0 to all ones
  function automatic logic [LUMA_FRACTION_BITS-1:0] sat_luma(logic [LIN_W-1:0] y);
    logic [LUMA_FRACTION_BITS:0] v;
    v = y[WORK_BITS -: LUMA_FRACTION_BITS + 1];
    return v[LUMA_FRACTION_BITS] ? '1 : v[LUMA_FRACTION_BITS-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Stage control: valid bits and bubble-collapsing load enables
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_r, vld_nxt, en;

  // Advance a stage when output is free or it or any later stage holds a bubble
  for (genvar g = 0; g < NST; g++) begin : g_en
    assign en[g] = !out_stall || !(&vld_r[NST-1:g]);
  end

  assign vld_nxt = (en & {vld_r[NST-2:0], in_valid}) | (~en & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NST-1];

  // --------------------------------------------------------------------------
  // Luminance of each color
  // --------------------------------------------------------------------------
  logic [LIN_W-1:0] y1, y2;

  ccr_luma u_luma_first (
    .clk   (clk),
    .en    (en[LUMA_STAGES-1:0]),
    .red   (in_data.first_red),
    .green (in_data.first_green),
    .blue  (in_data.first_blue),
    .luma  (y1)
  );

  ccr_luma u_luma_second (
    .clk   (clk),
    .en    (en[LUMA_STAGES-1:0]),
    .red   (in_data.second_red),
    .green (in_data.second_green),
    .blue  (in_data.second_blue),
    .luma  (y2)
  );

  // --------------------------------------------------------------------------
  // Order the luminances, then form the ratio's numerator and denominator
  // --------------------------------------------------------------------------
  logic [LIN_W-1:0]       hi_r, lo_r;
  logic [LUMA_PAIR_W-1:0] pair_cmp_r, pair_prp_r;
  logic [NUM_W-1:0]       num_r, den_r;

  always_ff @(posedge clk) begin
    if (en[CMP]) begin
      hi_r       <= (y1 > y2) ? y1 : y2;
      lo_r       <= (y1 > y2) ? y2 : y1;
      pair_cmp_r <= {sat_luma(y1), sat_luma(y2)};
    end
    if (en[PRP]) begin
      num_r      <= NUM_W'(hi_r) * RATIO_SCALE + WORK_ONE;
      den_r      <= NUM_W'(lo_r) * RATIO_SCALE + WORK_ONE;
      pair_prp_r <= pair_cmp_r;
    end
  end

  // --------------------------------------------------------------------------
  // Divide; the luminance pair rides along as a tag
  // --------------------------------------------------------------------------
  logic [RATIO_W-1:0]     quo;
  logic [LUMA_PAIR_W-1:0] pair_out;

  ccr_div u_div (
    .clk     (clk),
    .en      (en[NST-1:DV0]),
    .num     (num_r),
    .den     (den_r),
    .tag_in  (pair_prp_r),
    .quo     (quo),
    .tag_out (pair_out)
  );

  assign out_data.first_luminance  = pair_out[LUMA_PAIR_W-1:LUMA_FRACTION_BITS];
  assign out_data.second_luminance = pair_out[LUMA_FRACTION_BITS-1:0];
  assign out_data.contrast_value   = quo;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CCR_ASSERT_IMPL(a_full_stalls_input, clk, rst_n, (&vld_r) && out_stall, in_stall,
    "pipeline full with output stalled but input not stalled")
  `CCR_ASSERT_IMPL(a_bubble_takes_input, clk, rst_n, !(&vld_r) || !out_stall, !in_stall,
    "input stalled although a stage is free")
  `CCR_ASSERT_NEXT(a_beat_enters, clk, rst_n, in_valid && !in_stall, vld_r[0],
    "accepted beat did not enter the first stage")
  `CCR_ASSERT_IMPL(a_ratio_range, clk, rst_n, out_valid,
    (out_data.contrast_value >= RATIO_ONE) && (out_data.contrast_value <= RATIO_MAX),
    "contrast ratio outside 1.0 to 21.0")

endmodule

[tb/sv/tb_color_contrast_ratio.sv]
// ----------------------------------------------------------------------------
// tb_color_contrast_ratio
// Self-checking bench for the color contrast ratio pipeline. A short table of
// color pairs goes first (black, white, primaries, the linear/power knee,
// equal luminances), then random pairs under three idle/stall patterns. Every
// accepted result beat is checked field by field against hand-typed values or
// a bit-exact fixed-point predictor of luminance and ratio.
// ----------------------------------------------------------------------------
module tb_color_contrast_ratio;
  import ccr_pkg::*;

  localparam int          CLK_PERIOD   = 12;
  localparam int          RESET_CYCLES = 3;
  localparam int          RANDOM_PAIRS = 500;      // per idle pattern, three patterns
  localparam int          DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          FX_BITS      = 30;       // working format Q0.30
  localparam int          CODE_COUNT   = 1 << CHANNEL_BITS;

  localparam logic [LUMA_FRACTION_BITS-1:0] LUMA_FULL  = '1;
  localparam logic [RATIO_W-1:0]            RATIO_ONE  = RATIO_W'(1 << RATIO_FRACTION_BITS);
  localparam logic [RATIO_W-1:0]            RATIO_MAX  = RATIO_W'(21 << RATIO_FRACTION_BITS);

  typedef struct packed {
    ccr_in_t  pair;
    logic     typed;   // expected result given by hand in the table
    ccr_out_t want;
  } contrast_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  ccr_in_t   in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ccr_out_t  out_data;

  // Linear light value of every channel code, Q0.30
  bit [63:0]     linear_lut [CODE_COUNT];
  contrast_row_t pair_table [$];
  ccr_out_t      pending_results [$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  color_contrast_ratio dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------

  // Truncated Q0.30 product
  function automatic bit [63:0] q30_mul(input bit [63:0] a, input bit [63:0] b);
    return (a * b) >> FX_BITS;
  endfunction

  function automatic bit [63:0] q30_pow5(input bit [63:0] x);
    bit [63:0] p;
    p = q30_mul(x, x);
    p = q30_mul(p, x);
    p = q30_mul(p, x);
    return q30_mul(p, x);
  endfunction

  // WCAG linearization of one code: straight divide below the knee, else the
  // 2.4 power as t^2 * t^0.4 with the root found by bisection
  function automatic bit [63:0] code_to_linear(input bit [63:0] code);
    bit [63:0] full;
    bit [63:0] t;
    bit [63:0] sq;
    bit [63:0] lo;
    bit [63:0] hi;
    bit [63:0] mid;
    full = (64'd1 << CHANNEL_BITS) - 64'd1;
    if (code * 64'd100000 <= 64'd3928 * full) begin
      return ((code * 64'd100) << FX_BITS) / (64'd1292 * full);
    end
    t  = ((64'd1000 * code + 64'd55 * full) << FX_BITS) / (64'd1055 * full);
    sq = q30_mul(t, t);
    lo = 64'd0;
    hi = 64'd1 << FX_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'd1) / 64'd2;
      if (q30_pow5(mid) <= sq) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return q30_mul(sq, lo);
  endfunction

  // Unsaturated relative luminance, Q0.30
  function automatic bit [63:0] rel_luminance(input logic [CHANNEL_BITS-1:0] r,
                                              input logic [CHANNEL_BITS-1:0] g,
                                              input logic [CHANNEL_BITS-1:0] b);
    bit [63:0] sum;
    sum = 64'd2126 * linear_lut[r] + 64'd7152 * linear_lut[g] + 64'd722 * linear_lut[b];
    return sum / 64'd10000;
  endfunction

  function automatic logic [LUMA_FRACTION_BITS-1:0] luma_q16(input bit [63:0] y);
    bit [63:0] v;
    v = y >> (FX_BITS - LUMA_FRACTION_BITS);
    return (v > 64'(LUMA_FULL)) ? LUMA_FULL : v[LUMA_FRACTION_BITS-1:0];
  endfunction

  function automatic ccr_out_t predict_contrast(input ccr_in_t pair);
    bit [63:0] y1;
    bit [63:0] y2;
    bit [63:0] hi;
    bit [63:0] lo;
    bit [63:0] ratio;
    ccr_out_t  res;
    y1 = rel_luminance(pair.first_red, pair.first_green, pair.first_blue);
    y2 = rel_luminance(pair.second_red, pair.second_green, pair.second_blue);
    hi = (y1 > y2) ? y1 : y2;
    lo = (y1 > y2) ? y2 : y1;
    ratio = ((64'd20 * hi + (64'd1 << FX_BITS)) << RATIO_FRACTION_BITS) /
            (64'd20 * lo + (64'd1 << FX_BITS));
    res.first_luminance  = luma_q16(y1);
    res.second_luminance = luma_q16(y2);
    res.contrast_value   = ratio[RATIO_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic ccr_in_t make_pair(input int r1, input int g1, input int b1,
                                        input int r2, input int g2, input int b2);
    ccr_in_t p;
    p.first_red    = r1[CHANNEL_BITS-1:0];
    p.first_green  = g1[CHANNEL_BITS-1:0];
    p.first_blue   = b1[CHANNEL_BITS-1:0];
    p.second_red   = r2[CHANNEL_BITS-1:0];
    p.second_green = g2[CHANNEL_BITS-1:0];
    p.second_blue  = b2[CHANNEL_BITS-1:0];
    return p;
  endfunction

  // Append a table row; typed rows carry their expected luminances and ratio
  task automatic add_row(input ccr_in_t pair, input logic typed,
                         input logic [LUMA_FRACTION_BITS-1:0] lum1,
                         input logic [LUMA_FRACTION_BITS-1:0] lum2,
                         input logic [RATIO_W-1:0] ratio);
    contrast_row_t row;
    row.pair                  = pair;
    row.typed                 = typed;
    row.want.first_luminance  = lum1;
    row.want.second_luminance = lum2;
    row.want.contrast_value   = ratio;
    pair_table.push_back(row);
  endtask

  // Bias codes toward the ends of the range and the linear/power knee
  function automatic logic [CHANNEL_BITS-1:0] rand_channel();
    logic [CHANNEL_BITS-1:0] v;
    int unsigned             pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      v = $urandom_range(1) ? '1 : '0;
    end else if (pick < 30) begin
      v = CHANNEL_BITS'($urandom_range(13, 7));
    end else if (pick < 40) begin
      v = CHANNEL_BITS'($urandom_range(255, 248));
    end else begin
      v = CHANNEL_BITS'($urandom);
    end
    return v;
  endfunction

  function automatic ccr_in_t rand_pair();
    ccr_in_t     p;
    int unsigned kind;
    p.first_red    = rand_channel();
    p.first_green  = rand_channel();
    p.first_blue   = rand_channel();
    p.second_red   = rand_channel();
    p.second_green = rand_channel();
    p.second_blue  = rand_channel();
    kind = $urandom_range(99);
    if (kind < 12) begin
      // same color on both sides: ratio must come out as exactly 1.0
      p.second_red   = p.first_red;
      p.second_green = p.first_green;
      p.second_blue  = p.first_blue;
    end else if (kind < 20) begin
      // nearly equal colors: one code step apart in green
      p.second_red   = p.first_red;
      p.second_green = p.first_green ^ CHANNEL_BITS'(1);
      p.second_blue  = p.first_blue;
    end
    return p;
  endfunction

  // Present one beat, optionally after random idle cycles, and hold it until
  // the block takes it; queue its expected result on acceptance
  task automatic send_pair(input ccr_in_t pair, input ccr_out_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pair;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(want);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, exp, cycle_count);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result checker and sink stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    ccr_out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 32'(out_data.contrast_value), 0);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data.first_luminance !== exp_res.first_luminance) begin
          report_mismatch("first_luminance", 32'(out_data.first_luminance),
                          32'(exp_res.first_luminance));
        end
        if (out_data.second_luminance !== exp_res.second_luminance) begin
          report_mismatch("second_luminance", 32'(out_data.second_luminance),
                          32'(exp_res.second_luminance));
        end
        if (out_data.contrast_value !== exp_res.contrast_value) begin
          report_mismatch("contrast_value", 32'(out_data.contrast_value),
                          32'(exp_res.contrast_value));
        end
      end
    end
    // Stall the result side at the rate of the current pattern
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    ccr_out_t want;
    // Build the linearization table once
    for (int c = 0; c < CODE_COUNT; c++) begin
      linear_lut[c] = code_to_linear(64'(c));
    end

    // Directed pairs: black and white combos are typed in, the rest predicted
    add_row(make_pair(0, 0, 0, 0, 0, 0),             1'b1, '0, '0, RATIO_ONE);
    add_row(make_pair(255, 255, 255, 255, 255, 255), 1'b1, LUMA_FULL, LUMA_FULL, RATIO_ONE);
    add_row(make_pair(255, 255, 255, 0, 0, 0),       1'b1, LUMA_FULL, '0, RATIO_MAX);
    add_row(make_pair(0, 0, 0, 255, 255, 255),       1'b1, '0, LUMA_FULL, RATIO_MAX);
    add_row(make_pair(255, 0, 0, 0, 0, 0),           1'b0, '0, '0, '0);
    add_row(make_pair(0, 255, 0, 0, 0, 0),           1'b0, '0, '0, '0);
    add_row(make_pair(0, 0, 255, 0, 0, 0),           1'b0, '0, '0, '0);
    add_row(make_pair(0, 0, 0, 255, 0, 0),           1'b0, '0, '0, '0);
    add_row(make_pair(0, 0, 0, 0, 255, 0),           1'b0, '0, '0, '0);
    add_row(make_pair(0, 0, 0, 0, 0, 255),           1'b0, '0, '0, '0);
    add_row(make_pair(10, 10, 10, 11, 11, 11),       1'b0, '0, '0, '0);  // across the knee
    add_row(make_pair(10, 0, 0, 11, 0, 0),           1'b0, '0, '0, '0);
    add_row(make_pair(1, 1, 1, 0, 0, 0),             1'b0, '0, '0, '0);
    add_row(make_pair(254, 254, 254, 255, 255, 255), 1'b0, '0, '0, '0);
    add_row(make_pair(128, 128, 128, 128, 128, 128), 1'b0, '0, '0, '0);  // equal luminance
    add_row(make_pair(171, 34, 90, 171, 34, 90),     1'b0, '0, '0, '0);
    add_row(make_pair(255, 255, 254, 0, 0, 1),       1'b0, '0, '0, '0);
    add_row(make_pair(255, 0, 255, 0, 255, 0),       1'b0, '0, '0, '0);
    add_row(make_pair(85, 170, 255, 255, 170, 85),   1'b0, '0, '0, '0);

    // Hold reset, then release it for good
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pattern one: sender idles rarely, receiver stalls most of the time
    src_idle_pct   = 16;
    sink_stall_pct = 81;
    foreach (pair_table[i]) begin
      want = pair_table[i].typed ? pair_table[i].want : predict_contrast(pair_table[i].pair);
      send_pair(pair_table[i].pair, want);
    end
    for (int n = 0; n < 3 * RANDOM_PAIRS; n++) begin
      ccr_in_t pair;
      // Swap the pattern between thirds of the random part
      if (n == RANDOM_PAIRS) begin
        src_idle_pct   = 81;
        sink_stall_pct = 16;
      end else if (n == 2 * RANDOM_PAIRS) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      pair = rand_pair();
      send_pair(pair, predict_contrast(pair));
    end
    in_valid <= 1'b0;

    // Drain: wait for every pending result, then let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
